// ----- rtl/assert_macros.svh -----
// assertion helpers, sampled on the block clock and muted during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define SRP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/srp_pkg.sv -----
`default_nettype none

package srp_pkg;

  localparam logic [0:0] KindData   = 1'b0;
  localparam logic [0:0] KindStatus = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusCsumErr = 2'd2;

  typedef struct packed {
    logic [0:0]  kind;
    logic [3:0]  record_type;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [23:0] record_count;
    logic [7:0]  data_count;
    logic [1:0]  status;
  } srp_res_t;

endpackage

`default_nettype wire

// ----- rtl/srecord_line_parser.sv -----
// s-record line parser
//
// input channel: one ascii character per request (ch_i), with first_i set on
// the first character of each record line; in_valid_i / in_stall_o.
// output channel: one result request per data byte (kind 0, with its address)
// and one status request per record (kind 1: ok, not valid, checksum error);
// out_valid_o / out_stall_i.
// a character is accepted when in_valid_i is high and in_stall_o is low.
// a result from an accepted character is registered in the output register,
// or in the skid register when the output stalls. throughput: one character
// per cycle while in_stall_o is low; each character needs only a nibble
// decode and a few register updates in the parser, and its result lands in a
// two-entry output buffer (output register plus skid register).
// when the receiver stalls, the pending result holds on the outputs and the
// skid register takes one more; in_stall_o is high exactly while the skid
// register is occupied, from the cycle after a stalled edge that took a new
// result until the edge at which the output drains.
// reset: asynchronous, active low; parser returns to idle waiting for a
// record start and both buffer entries empty.
`default_nettype none

module srecord_line_parser import srp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        first_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             kind_o,
  output logic [3:0]       record_type_o,
  output logic [31:0]      address_o,
  output logic [7:0]       data_byte_o,
  output logic [23:0]      record_count_o,
  output logic [7:0]       data_count_o,
  output logic [1:0]       status_o
);

  logic     in_acc;
  logic     res_vld;
  srp_res_t res;
  srp_res_t out_res;
  logic     buf_full;

  // stall only while the skid entry is taken, so a new result always fits
  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  // record state machine, hex decode and checksum
  srp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_acc),
    .ch_i      (ch_i),
    .first_i   (first_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // result register with skid entry
  srp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .out_vld_o   (out_valid_o),
    .out_o       (out_res),
    .full_o      (buf_full)
  );

  assign kind_o         = out_res.kind;
  assign record_type_o  = out_res.record_type;
  assign address_o      = out_res.address;
  assign data_byte_o    = out_res.data_byte;
  assign record_count_o = out_res.record_count;
  assign data_count_o   = out_res.data_count;
  assign status_o       = out_res.status;

endmodule

`default_nettype wire

// ----- rtl/srp_parser.sv -----
`default_nettype none

module srp_parser import srp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       first_i,
  output logic            res_vld_o,
  output srp_res_t        res_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_TYPE, PH_COUNT, PH_FIELD, PH_DATA, PH_CSUM, PH_SKIP
  } phase_e;

  localparam logic [7:0] CharS    = 8'h53;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpF  = 8'h46;
  localparam logic [7:0] CharLoA  = 8'h61;
  localparam logic [7:0] CharLoF  = 8'h66;
  localparam logic [7:0] SumGood  = 8'hFF;
  localparam logic [7:0] HexTen   = 8'd11 - 8'd1;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CharZero && c <= CharNine) t = c - CharZero;
    else if (c >= CharUpA && c <= CharUpF) t = c - CharUpA + HexTen;
    else if (c >= CharLoA && c <= CharLoF) t = c - CharLoA + HexTen;
    return t[3:0];
  endfunction

  function automatic logic [2:0] field_bytes(input logic [3:0] t);
    logic [2:0] n;
    case (t)
      4'd0, 4'd1, 4'd5, 4'd9: n = 3'd2;
      4'd2, 4'd6, 4'd8:       n = 3'd3;
      4'd3, 4'd7:             n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  nib_high_q, nib_high_d;
  logic        nib_pend_q, nib_pend_d;
  logic [3:0]  rec_type_q, rec_type_d;
  logic [7:0]  byte_total_q, byte_total_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [31:0] field_q, field_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  data_index_q, data_index_d;
  logic        failed_q, failed_d;

  always_comb begin
    logic [3:0]  v;
    logic [7:0]  b;
    logic [7:0]  fb8;
    logic [7:0]  dlen;
    logic [7:0]  bl;
    logic [7:0]  sum_n;
    logic [31:0] start;
    logic        fail_n;
    phase_d      = phase_q;
    nib_high_d   = nib_high_q;
    nib_pend_d   = nib_pend_q;
    rec_type_d   = rec_type_q;
    byte_total_d = byte_total_q;
    bytes_left_d = bytes_left_q;
    field_d      = field_q;
    sum_d        = sum_q;
    data_index_d = data_index_q;
    failed_d     = failed_q;
    res_vld_o    = 1'b0;
    res_o        = '0;
    v     = hex_val(ch_i);
    b     = {nib_high_q, v};
    fb8   = {5'd0, field_bytes(rec_type_q)};
    dlen  = (rec_type_q <= 4'd3) ? (byte_total_q - fb8 - 8'd1) : 8'd0;
    bl    = bytes_left_q - 8'd1;
    sum_n = sum_q + b;
    start = (rec_type_q == 4'd0) ? 32'd0 : field_q;
    fail_n = failed_q || (b < fb8 + 8'd1) ||
             ((rec_type_q >= 4'd5) && (b != fb8 + 8'd1));

    if (acc_i) begin
      if (first_i) begin
        nib_high_d   = '0;
        nib_pend_d   = 1'b0;
        rec_type_d   = '0;
        byte_total_d = '0;
        bytes_left_d = '0;
        field_d      = '0;
        sum_d        = '0;
        data_index_d = '0;
        failed_d     = 1'b0;
        phase_d      = (ch_i == CharS) ? PH_TYPE : PH_IDLE;
        if (phase_q != PH_IDLE) begin
          res_vld_o = 1'b1;
          res_o.kind = KindStatus;
          res_o.record_type = rec_type_q;
          res_o.status = StatusInvalid;
        end else if (ch_i != CharS) begin
          res_vld_o = 1'b1;
          res_o.kind = KindStatus;
          res_o.status = StatusInvalid;
        end
      end else if (phase_q == PH_IDLE) begin
        phase_d = PH_IDLE;
      end else if (phase_q == PH_TYPE) begin
        if (ch_i >= CharZero && ch_i <= CharNine) begin
          rec_type_d = ch_i[3:0];
          if (ch_i[3:0] == 4'd4) failed_d = 1'b1;
        end else begin
          rec_type_d = '0;
          failed_d   = 1'b1;
        end
        nib_pend_d = 1'b0;
        phase_d    = PH_COUNT;
      end else if (!nib_pend_q) begin
        nib_high_d = v;
        nib_pend_d = 1'b1;
      end else begin
        nib_pend_d = 1'b0;
        case (phase_q)
          PH_COUNT: begin
            byte_total_d = b;
            sum_d        = b;
            failed_d     = fail_n;
            if (fail_n) begin
              bytes_left_d = b;
              if (b == 8'd0) begin
                res_vld_o = 1'b1;
                res_o.kind = KindStatus;
                res_o.record_type = rec_type_q;
                res_o.status = StatusInvalid;
                phase_d = PH_IDLE;
              end else begin
                phase_d = PH_SKIP;
              end
            end else begin
              bytes_left_d = fb8;
              field_d      = '0;
              phase_d      = PH_FIELD;
            end
          end
          PH_FIELD: begin
            field_d = {field_q[23:0], b};
            sum_d   = sum_n;
            if (bl == 8'd0) begin
              bytes_left_d = dlen;
              phase_d = (dlen != 8'd0) ? PH_DATA : PH_CSUM;
            end else begin
              bytes_left_d = bl;
            end
          end
          PH_DATA: begin
            sum_d = sum_n;
            res_vld_o = 1'b1;
            res_o.kind = KindData;
            res_o.record_type = rec_type_q;
            res_o.address = start + {24'd0, data_index_q};
            res_o.data_byte = b;
            res_o.data_count = dlen;
            res_o.status = StatusOk;
            data_index_d = data_index_q + 8'd1;
            bytes_left_d = bl;
            if (bl == 8'd0) phase_d = PH_CSUM;
          end
          PH_CSUM: begin
            sum_d = sum_n;
            res_vld_o = 1'b1;
            res_o.kind = KindStatus;
            res_o.record_type = rec_type_q;
            res_o.data_count = dlen;
            res_o.status = (sum_n == SumGood) ? StatusOk : StatusCsumErr;
            if (rec_type_q == 4'd5 || rec_type_q == 4'd6) begin
              res_o.record_count = field_q[23:0];
            end else if (rec_type_q != 4'd0) begin
              res_o.address = field_q;
            end
            phase_d = PH_IDLE;
          end
          PH_SKIP: begin
            bytes_left_d = bl;
            if (bl == 8'd0) begin
              res_vld_o = 1'b1;
              res_o.kind = KindStatus;
              res_o.record_type = rec_type_q;
              res_o.status = StatusInvalid;
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      nib_high_q   <= '0;
      nib_pend_q   <= 1'b0;
      rec_type_q   <= '0;
      byte_total_q <= '0;
      bytes_left_q <= '0;
      field_q      <= '0;
      sum_q        <= '0;
      data_index_q <= '0;
      failed_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      nib_high_q   <= nib_high_d;
      nib_pend_q   <= nib_pend_d;
      rec_type_q   <= rec_type_d;
      byte_total_q <= byte_total_d;
      bytes_left_q <= bytes_left_d;
      field_q      <= field_d;
      sum_q        <= sum_d;
      data_index_q <= data_index_d;
      failed_q     <= failed_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/srp_out_buf.sv -----
`default_nettype none
`include "assert_macros.svh"

module srp_out_buf import srp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     res_vld_i,
  input  wire srp_res_t res_i,
  input  wire logic     out_stall_i,
  output logic          out_vld_o,
  output srp_res_t      out_o,
  output logic          full_o
);

  logic     out_vld_q;
  logic     skid_vld_q;
  srp_res_t out_q;
  srp_res_t skid_q;
  logic     pop;
  logic     load;

  assign pop  = out_vld_q && !out_stall_i;
  assign load = !out_vld_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (load) out_vld_q <= skid_vld_q || res_vld_i;
      if (skid_vld_q && pop) skid_vld_q <= 1'b0;
      else if (res_vld_i && !load) skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= skid_vld_q ? skid_q : res_i;
    if (res_vld_i && !load) skid_q <= res_i;
  end

  assign out_vld_o = out_vld_q;
  assign out_o     = out_q;
  assign full_o    = skid_vld_q;

  `SRP_ASSERT_ALWAYS(a_skid_needs_out, !skid_vld_q || out_vld_q, "skid set with output empty")
  `SRP_ASSERT_ALWAYS(a_no_push_when_full, !(res_vld_i && skid_vld_q), "push into full skid")
  `SRP_ASSERT_NEXT(a_skid_fills, out_vld_q && out_stall_i && res_vld_i, skid_vld_q, "request lost")
  `SRP_ASSERT_NEXT(a_skid_drains, skid_vld_q && !out_stall_i, !skid_vld_q, "skid not drained")

endmodule

`default_nettype wire

// ----- verif/srecord_line_parser_tb.sv -----
`default_nettype none

module srecord_line_parser_tb import srp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // parser progress through one record line
  typedef enum logic [2:0] {
    PsIdle,
    PsType,
    PsCount,
    PsField,
    PsData,
    PsCsum,
    PsSkip
  } parse_stage_e;

  // one character request with the idle cycles that come before it
  typedef struct {
    logic [7:0]  ch;
    logic        first;
    int unsigned gap;
  } char_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i = 8'h00;
  logic        first_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [3:0]  record_type_o;
  logic [31:0] address_o;
  logic [7:0]  data_byte_o;
  logic [23:0] record_count_o;
  logic [7:0]  data_count_o;
  logic [1:0]  status_o;

  srecord_line_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .record_type_o  (record_type_o),
    .address_o      (address_o),
    .data_byte_o    (data_byte_o),
    .record_count_o (record_count_o),
    .data_count_o   (data_count_o),
    .status_o       (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // line decoder: mirrors the block's per-record state
  // ---------------------------------------------------------------------
  parse_stage_e stage = PsIdle;
  logic [3:0]   hi_nib = '0;
  logic         nib_half = 1'b0;
  logic [3:0]   cur_type = '0;
  logic [7:0]   rec_len = '0;
  logic [7:0]   remain = '0;
  logic [31:0]  fld = '0;
  logic [7:0]   chk_sum = '0;
  logic [7:0]   byte_idx = '0;
  logic         rec_bad = 1'b0;

  srp_res_t     owed_results[$];
  int unsigned  mismatches = 0;

  // non-hex characters decode as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'd0;
  endfunction

  // address / count field width in bytes for each record type
  function automatic logic [7:0] field_len(input logic [3:0] t);
    case (t)
      4'd0, 4'd1, 4'd5, 4'd9: return 8'd2;
      4'd2, 4'd6, 4'd8:       return 8'd3;
      4'd3, 4'd7:             return 8'd4;
      default:                return 8'd0;
    endcase
  endfunction

  // data bytes carried by the record in progress (only s0..s3 carry any)
  function automatic logic [7:0] payload_len();
    if (cur_type <= 4'd3) return rec_len - field_len(cur_type) - 8'd1;
    return 8'd0;
  endfunction

  function automatic void clear_record();
    hi_nib = '0;
    nib_half = 1'b0;
    cur_type = '0;
    rec_len = '0;
    remain = '0;
    fld = '0;
    chk_sum = '0;
    byte_idx = '0;
    rec_bad = 1'b0;
  endfunction

  // not-valid status carries only kind, type and status
  function automatic void owe_invalid(input logic [3:0] t);
    srp_res_t r;
    r = '0;
    r.kind = KindStatus;
    r.record_type = t;
    r.status = StatusInvalid;
    owed_results.push_back(r);
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic f);
    logic        was_busy;
    logic [3:0]  prev_type;
    logic [7:0]  b;
    logic [7:0]  fb;
    srp_res_t    r;
    r = '0;
    if (f) begin
      // a start flag always ends any record in progress and opens a new one on S
      was_busy = (stage != PsIdle);
      prev_type = cur_type;
      clear_record();
      stage = (c == "S") ? PsType : PsIdle;
      if (was_busy) owe_invalid(prev_type);
      else if (c != "S") owe_invalid(4'd0);
      return;
    end
    // stray characters between records are dropped
    if (stage == PsIdle) return;
    if (stage == PsType) begin
      if (c >= "0" && c <= "9") begin
        cur_type = 4'(c - "0");
        if (cur_type == 4'd4) rec_bad = 1'b1;
      end else begin
        cur_type = 4'd0;
        rec_bad = 1'b1;
      end
      nib_half = 1'b0;
      stage = PsCount;
      return;
    end
    if (!nib_half) begin
      hi_nib = nibble_of(c);
      nib_half = 1'b1;
      return;
    end
    nib_half = 1'b0;
    b = {hi_nib, nibble_of(c)};
    fb = field_len(cur_type);
    case (stage)
      PsCount: begin
        rec_len = b;
        chk_sum = b;
        if (!rec_bad) begin
          if (b < fb + 8'd1) rec_bad = 1'b1;
          if (cur_type >= 4'd5 && b != fb + 8'd1) rec_bad = 1'b1;
        end
        if (rec_bad) begin
          // swallow count-many bytes, then report not valid
          remain = b;
          if (remain == 8'd0) begin
            owe_invalid(cur_type);
            stage = PsIdle;
          end else begin
            stage = PsSkip;
          end
        end else begin
          remain = fb;
          fld = '0;
          stage = PsField;
        end
      end
      PsField: begin
        fld = {fld[23:0], b};
        chk_sum = chk_sum + b;
        remain = remain - 8'd1;
        if (remain == 8'd0) begin
          remain = payload_len();
          stage = (remain != 8'd0) ? PsData : PsCsum;
        end
      end
      PsData: begin
        chk_sum = chk_sum + b;
        r.kind = KindData;
        r.record_type = cur_type;
        r.address = ((cur_type == 4'd0) ? 32'd0 : fld) + 32'(byte_idx);
        r.data_byte = b;
        r.data_count = payload_len();
        r.status = StatusOk;
        owed_results.push_back(r);
        byte_idx = byte_idx + 8'd1;
        remain = remain - 8'd1;
        if (remain == 8'd0) stage = PsCsum;
      end
      PsCsum: begin
        // ones-complement rule: bytes from count through checksum sum to ff
        chk_sum = chk_sum + b;
        r.kind = KindStatus;
        r.record_type = cur_type;
        r.status = (chk_sum == 8'hFF) ? StatusOk : StatusCsumErr;
        if (cur_type == 4'd5 || cur_type == 4'd6) r.record_count = fld[23:0];
        else if (cur_type != 4'd0) r.address = fld;
        r.data_count = payload_len();
        owed_results.push_back(r);
        stage = PsIdle;
      end
      PsSkip: begin
        remain = remain - 8'd1;
        if (remain == 8'd0) begin
          owe_invalid(cur_type);
          stage = PsIdle;
        end
      end
      default: stage = PsIdle;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // stimulus: character requests queued up front
  // ---------------------------------------------------------------------
  char_req_t   char_reqs[$];
  logic [7:0]  line_buf[$];
  bit          calm = 1'b0;
  int unsigned reqs_total = 0;
  int unsigned reqs_sent = 0;

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_char(input logic [7:0] c, input logic f);
    char_req_t q;
    q.ch = c;
    q.first = f;
    q.gap = pick_gap();
    char_reqs.push_back(q);
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == 0);
  endfunction

  // hex letters in either case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
  endfunction

  function automatic void add_hex_byte(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endfunction

  // one record line, well formed most of the time, with an occasional flaw
  task automatic queue_record(input bit full_len);
    logic [3:0]  t;
    logic [7:0]  fbn;
    logic [7:0]  cnt;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [31:0] addr;
    int unsigned flaw;
    int unsigned r;
    int unsigned dlen;
    int unsigned cut;
    line_buf = {};
    calm = ($urandom_range(0, 4) == 0);
    flaw = full_len ? 0 : $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (full_len) t = 4'd3;
    else if (r < 55) t = 4'($urandom_range(1, 3));
    else if (r < 65) t = 4'd0;
    else t = 4'($urandom_range(5, 9));
    fbn = field_len(t);
    line_buf.push_back("S");
    if (flaw >= 82 && flaw < 87) begin
      // type '4' or a non-digit type, then count-many junk bytes
      if ($urandom_range(0, 1)) begin
        b = "4";
      end else begin
        do b = 8'($urandom_range(0, 255)); while (b >= "0" && b <= "9");
      end
      line_buf.push_back(b);
      cnt = 8'($urandom_range(0, 5));
      add_hex_byte(cnt);
      for (int i = 0; i < cnt; i++) add_hex_byte(8'($urandom_range(0, 255)));
    end else if (flaw >= 87 && flaw < 92) begin
      // count too small, or not exact for the non-data types
      line_buf.push_back("0" + 8'(t));
      if (t <= 4'd3) begin
        cnt = 8'($urandom_range(0, fbn));
      end else begin
        do cnt = 8'($urandom_range(0, 8)); while (cnt == fbn + 8'd1);
      end
      add_hex_byte(cnt);
      for (int i = 0; i < cnt; i++) add_hex_byte(8'($urandom_range(0, 255)));
    end else begin
      line_buf.push_back("0" + 8'(t));
      r = $urandom_range(0, 99);
      if (t > 4'd3) dlen = 0;
      else if (full_len) dlen = 255 - fbn - 1;
      else if (r < 70) dlen = $urandom_range(0, 8);
      else if (r < 97) dlen = $urandom_range(9, 32);
      else dlen = $urandom_range(33, 100);
      r = $urandom_range(0, 99);
      if (r < 30) addr = 32'hFFFF_FFFF - $urandom_range(0, 8);
      else if (r < 40) addr = 32'd0;
      else addr = $urandom;
      cnt = fbn + 8'd1 + 8'(dlen);
      sum = cnt;
      add_hex_byte(cnt);
      // big-endian field
      for (int i = fbn - 1; i >= 0; i--) begin
        b = addr[8*i +: 8];
        sum = sum + b;
        add_hex_byte(b);
      end
      for (int i = 0; i < dlen; i++) begin
        b = 8'($urandom_range(0, 255));
        sum = sum + b;
        add_hex_byte(b);
      end
      b = ~sum;
      if (flaw >= 68 && flaw < 78) b = b ^ 8'($urandom_range(1, 255));
      add_hex_byte(b);
      if (flaw >= 78 && flaw < 82) begin
        // bad lead character: whole line then falls outside a record
        do b = 8'($urandom_range(0, 255)); while (b == "S");
        line_buf[0] = b;
      end else if (flaw >= 92 && flaw < 97) begin
        // cut short: the next start flag ends it
        cut = $urandom_range(1, line_buf.size() - 1);
        line_buf = line_buf[0:cut-1];
      end else if (flaw >= 97) begin
        // garbage byte somewhere past the lead and type characters
        line_buf[$urandom_range(2, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    foreach (line_buf[i]) push_char(line_buf[i], i == 0);
    r = $urandom_range(0, 99);
    if (r < 25) begin
      push_char(8'h0D, 1'b0);
      push_char(8'h0A, 1'b0);
    end else if (r < 35) begin
      for (int i = $urandom_range(1, 4); i > 0; i--) push_char(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // driver: presents queued requests, holds them while stalled
  // ---------------------------------------------------------------------
  char_req_t   staged_req;
  bit          staged = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(ch_i, first_i);
        reqs_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (!staged && char_reqs.size() != 0) begin
          staged_req = char_reqs.pop_front();
          staged = 1'b1;
          gap_left = staged_req.gap;
        end
        if (staged && gap_left == 0) begin
          in_valid_i <= 1'b1;
          ch_i <= staged_req.ch;
          first_i <= staged_req.first;
          staged = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks each accepted result, drives random stalls
  // ---------------------------------------------------------------------
  int unsigned stall_left = 0;
  logic [15:0] cyc = '0;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    int unsigned pick;
    srp_res_t    want;
    if (rst_ni) begin
      cyc <= cyc + 16'd1;
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing expected: kind %0h type %0h status %0h",
                 kind_o, record_type_o, status_o);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_o));
          check_field("record_type", 32'(want.record_type), 32'(record_type_o));
          check_field("address", want.address, address_o);
          check_field("data_byte", 32'(want.data_byte), 32'(data_byte_o));
          check_field("record_count", 32'(want.record_count), 32'(record_count_o));
          check_field("data_count", 32'(want.data_count), 32'(data_count_o));
          check_field("status", 32'(want.status), 32'(status_o));
        end
      end
      // stalls: none in the quiet window, else mostly short and a few long
      if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (cyc[9:8] == 2'b11 || pick < 60) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (pick < 93) ? $urandom_range(0, 2) : $urandom_range(14, 59);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------
  initial begin
    int unsigned n;
    // directed: bad lead, cut before the type, type '4' with zero count,
    // non-digit type with a non-hex skipped byte, all-ones s3 address with a
    // lower-case checksum, then a line end outside any record
    queue_text("Z");
    queue_text("S");
    queue_text("S400");
    queue_text("Sx01gg");
    queue_text("S305FFFFFFFFfe");
    push_char(8'h0A, 1'b0);
    n = 0;
    while (char_reqs.size() < 1730) begin
      queue_record(n == 8);
      n++;
    end
    // closing start flag so a cut-short last line still gets its status
    push_char("S", 1'b1);
    reqs_total = char_reqs.size();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (reqs_sent < reqs_total) @(negedge clk_i);
    while (owed_results.size() != 0) @(negedge clk_i);
    // room for a stray result behind a long stall
    repeat (100) @(negedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/srp_pkg.sv
rtl/srp_parser.sv
rtl/srp_out_buf.sv
rtl/srecord_line_parser.sv
verif/srecord_line_parser_tb.sv
